/* src/pcg_pkg.sv */
// Shared types and constants for the particle gravity step pipeline.
package pcg_pkg;

	// Gravitational parameter G*M of the central body, m^3/s^2 (integer).
	localparam int unsigned MU_W = 49;
	localparam logic [MU_W-1:0] GRAV_MU = 49'd398695201600000;
	// MU * dt, dt unsigned Q16.16.
	localparam int unsigned MUDT_W = MU_W + 32;
	// Dividend of the K division: MU * dt * 2^28.
	localparam int unsigned KNUM_W = MUDT_W + 28;

	localparam int unsigned SQRT_STEPS = 32;
	localparam int unsigned UDIV_STEPS = 31;
	localparam int unsigned KDIV_STEPS = KNUM_W;

	// Cap on the magnitude of one velocity change.
	localparam logic [33:0] DV_CAP = 34'h2_0000_0000;

	typedef enum logic [1:0] {
		REG_STEP  = 2'd0,
		REG_CAM_X = 2'd1,
		REG_CAM_Y = 2'd2,
		REG_CAM_Z = 2'd3
	} reg_idx_t;

	// One particle as it travels down the pipeline.
	typedef struct packed {
		logic [2:0][63:0] pos;
		logic [2:0][31:0] vel;
		logic [31:0]      life;
		logic [15:0]      tag;
		logic [5:0]       sh;
		logic [2:0][30:0] q;
		logic [63:0]      r2;
		logic [31:0]      r;
		logic [2:0][30:0] u;
		logic [63:0]      k;
		logic             kovf;
	} pcg_item_t;

	typedef struct packed {
		logic [2:0][63:0] new_pos;
		logic [2:0][31:0] new_vel;
		logic [31:0]      new_life;
		logic [2:0][63:0] view;
		logic [15:0]      tag;
	} pcg_result_t;

endpackage

/* src/pcg_front.sv */
// Front stages: expiry, range shift, scaled components, squared radius.
module pcg_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                in_vld,
	input  pcg_pkg::pcg_item_t  in_item,
	input  logic [31:0]         dt,
	output logic                out_vld,
	output pcg_pkg::pcg_item_t  out_item
);

	logic               vld_s1, vld_s2, vld_s3, vld_s4;
	pcg_pkg::pcg_item_t item_s1, item_s2, item_s3, item_s4;
	logic [2:0][63:0]   mag_s1;
	logic [63:0]        mor_s1;
	logic [2:0][61:0]   sq_s3;
	logic [2:0][63:0]   mag_c;
	logic [5:0]         sh_c;
	pcg_pkg::pcg_item_t item2_c;
	pcg_pkg::pcg_item_t item4_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = in_item.pos[i][63] ? (~in_item.pos[i] + 64'd1) : in_item.pos[i];
		end
	end

	// smallest shift that brings the largest magnitude below 2^31
	always_comb begin
		sh_c = '0;
		for (int i = 31; i < 64; i++) begin
			if (mor_s1[i]) sh_c = 6'(i - 30);
		end
		item2_c = item_s1;
		item2_c.sh = sh_c;
		for (int i = 0; i < 3; i++) begin
			item2_c.q[i] = 31'(mag_s1[i] >> sh_c);
		end
	end

	always_comb begin
		item4_c    = item_s3;
		item4_c.r2 = 64'(sq_s3[0]) + 64'(sq_s3[1]) + 64'(sq_s3[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld && (in_item.life > dt);
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= in_item;
			mag_s1  <= mag_c;
			mor_s1  <= mag_c[0] | mag_c[1] | mag_c[2];
			item_s2 <= item2_c;
			item_s3 <= item_s2;
			for (int i = 0; i < 3; i++) begin
				sq_s3[i] <= item_s2.q[i] * item_s2.q[i];
			end
			item_s4 <= item4_c;
		end
	end

	assign out_vld  = vld_s4;
	assign out_item = item_s4;

	// a nonzero shift leaves the largest component with its top bit set
	assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && item_s2.sh != '0) |->
			(item_s2.q[0][30] || item_s2.q[1][30] || item_s2.q[2][30]))
		else $error("front: scaled component out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		(adv && in_vld && in_item.life <= dt) |=> !vld_s1)
		else $error("front: expired particle entered pipeline");

	assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && mor_s1[63:31] == '0) |-> (sh_c == '0))
		else $error("front: shift on small position");

endmodule

/* src/pcg_isqrt.sv */
// Pipelined integer square root of the squared radius, one result bit per stage.
module pcg_isqrt (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                in_vld,
	input  pcg_pkg::pcg_item_t  in_item,
	output logic                out_vld,
	output pcg_pkg::pcg_item_t  out_item
);

	localparam int unsigned N = pcg_pkg::SQRT_STEPS;

	logic               vld_s  [1:N];
	pcg_pkg::pcg_item_t item_s [1:N];
	logic [63:0]        n_s    [1:N];
	logic [63:0]        res_s  [1:N];

	for (genvar j = 0; j < N; j++) begin : g_stg
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
		logic               v_i;
		pcg_pkg::pcg_item_t it_i;
		logic [63:0]        n_i, res_i;
		logic [64:0]        t;
		logic               ge;

		if (j == 0) begin : g_first
			assign v_i   = in_vld;
			assign it_i  = in_item;
			assign n_i   = in_item.r2;
			assign res_i = '0;
		end else begin : g_mid
			assign v_i   = vld_s[j];
			assign it_i  = item_s[j];
			assign n_i   = n_s[j];
			assign res_i = res_s[j];
		end

		assign t  = {1'b0, res_i} + {1'b0, BIT};
		assign ge = {1'b0, n_i} >= t;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (adv) begin
				vld_s[j+1] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				item_s[j+1] <= it_i;
				n_s[j+1]    <= ge ? (n_i - t[63:0]) : n_i;
				res_s[j+1]  <= ge ? ((res_i >> 1) + BIT) : (res_i >> 1);
			end
		end
	end

	always_comb begin
		out_item   = item_s[N];
		out_item.r = res_s[N][31:0];
	end
	assign out_vld = vld_s[N];

endmodule

/* src/pcg_udiv.sv */
// Pipelined unit-vector divider: u = q * 2^30 / r for three axes in parallel.
module pcg_udiv (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                in_vld,
	input  pcg_pkg::pcg_item_t  in_item,
	output logic                out_vld,
	output pcg_pkg::pcg_item_t  out_item
);

	localparam int unsigned N = pcg_pkg::UDIV_STEPS;

	logic               vld_s  [1:N];
	pcg_pkg::pcg_item_t item_s [1:N];
	logic [2:0][31:0]   rem_s  [1:N];

	for (genvar j = 0; j < N; j++) begin : g_stg
		localparam int unsigned QB = N - 1 - j;
		logic               v_i;
		pcg_pkg::pcg_item_t it_i, it_o;
		logic [2:0][31:0]   rem_i, rem_o;
		logic [2:0]         ge;

		if (j == 0) begin : g_first
			always_comb begin
				it_i   = in_item;
				it_i.u = '0;
				for (int l = 0; l < 3; l++) begin
					rem_i[l] = {2'b0, in_item.q[l][30:1]};
				end
			end
			assign v_i = in_vld;
		end else begin : g_mid
			assign v_i   = vld_s[j];
			assign it_i  = item_s[j];
			assign rem_i = rem_s[j];
		end

		always_comb begin
			logic       nbit;
			logic [32:0] sh;
			it_o = it_i;
			for (int l = 0; l < 3; l++) begin
				nbit = (j == 0) ? it_i.q[l][0] : 1'b0;
				sh   = {rem_i[l], nbit};
				ge[l] = sh >= {1'b0, it_i.r};
				rem_o[l] = ge[l] ? 32'(sh - {1'b0, it_i.r}) : sh[31:0];
				it_o.u[l][QB] = ge[l];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (adv) begin
				vld_s[j+1] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				item_s[j+1] <= it_o;
				rem_s[j+1]  <= rem_o;
			end
		end
	end

	assign out_vld  = vld_s[N];
	assign out_item = item_s[N];

endmodule

/* src/pcg_kdiv.sv */
// Pipelined long divider: K = floor(MU*dt*2^28 / 2^(2s) / r2), one bit per stage.
module pcg_kdiv (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic                              in_vld,
	input  pcg_pkg::pcg_item_t                in_item,
	input  logic [pcg_pkg::MUDT_W-1:0]        mudt,
	output logic                              out_vld,
	output pcg_pkg::pcg_item_t                out_item
);

	localparam int unsigned N  = pcg_pkg::KDIV_STEPS;
	localparam int unsigned NW = pcg_pkg::KNUM_W;

	logic               vld_s  [0:N];
	pcg_pkg::pcg_item_t item_s [0:N];
	logic [NW-1:0]      nn_s   [0:N];
	logic [63:0]        rem_s  [0:N];
	pcg_pkg::pcg_item_t item0_c;

	always_comb begin
		item0_c      = in_item;
		item0_c.k    = '0;
		item0_c.kovf = 1'b0;
	end

	// entry stage: scale the dividend by 2^-2s
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s[0] <= item0_c;
			nn_s[0]   <= NW'({mudt, 28'd0} >> {in_item.sh, 1'b0});
			rem_s[0]  <= '0;
		end
	end

	for (genvar j = 0; j < N; j++) begin : g_stg
		localparam int unsigned QB = N - 1 - j;
		pcg_pkg::pcg_item_t it_o;
		logic [64:0]        sh;
		logic               ge;
		logic [63:0]        rem_o;

		assign sh    = {rem_s[j], nn_s[j][QB]};
		assign ge    = sh >= {1'b0, item_s[j].r2};
		assign rem_o = ge ? 64'(sh - {1'b0, item_s[j].r2}) : sh[63:0];

		always_comb begin
			it_o = item_s[j];
			if (QB >= 64) begin
				it_o.kovf = item_s[j].kovf | ge;
			end else begin
				it_o.k[QB % 64] = ge;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (adv) begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				item_s[j+1] <= it_o;
				nn_s[j+1]   <= nn_s[j];
				rem_s[j+1]  <= rem_o;
			end
		end
	end

	assign out_vld  = vld_s[N];
	assign out_item = item_s[N];

endmodule

/* src/pcg_back.sv */
// Back stages: velocity change, velocity and position update, camera-relative view.
module pcg_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 in_vld,
	input  pcg_pkg::pcg_item_t   in_item,
	input  logic [31:0]          dt,
	input  logic [2:0][63:0]     cam,
	output logic                 out_vld,
	output pcg_pkg::pcg_result_t out_res
);

	function automatic logic [63:0] sat64(input logic [64:0] x);
		if (x[64] != x[63]) return x[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		return x[63:0];
	endfunction

	logic               vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	pcg_pkg::pcg_item_t item_s1, item_s2, item_s3, item_s4, item_s5;
	logic [2:0][62:0]   plo_s1, phi_s1;
	logic [2:0][33:0]   mag_s2;
	logic [2:0][31:0]   nv_s3, nv_s4, nv_s5;
	logic [2:0][63:0]   pd_s4;
	logic [2:0][63:0]   np_s5;
	pcg_pkg::pcg_result_t res_s6;

	logic [63:0]        kc;
	logic [2:0][33:0]   mag_c;
	logic [2:0][31:0]   nv_c;
	logic [2:0][63:0]   pd_c;
	logic [2:0][63:0]   np_c;
	pcg_pkg::pcg_result_t res_c;

	assign kc = in_item.kovf ? '1 : in_item.k;

	// (K*u + 2^29) >> 30, capped
	always_comb begin
		logic [95:0] prod;
		logic [65:0] mf;
		for (int l = 0; l < 3; l++) begin
			prod = {1'b0, phi_s1[l], 32'd0} + {33'd0, plo_s1[l]} + 96'(32'h2000_0000);
			mf   = prod[95:30];
			mag_c[l] = (mf > 66'(pcg_pkg::DV_CAP)) ? pcg_pkg::DV_CAP : mf[33:0];
		end
	end

	// v' = v + dv, saturated
	always_comb begin
		logic [35:0] dv, vw;
		for (int l = 0; l < 3; l++) begin
			if (item_s2.r2 == '0) dv = '0;
			else if (item_s2.pos[l][63]) dv = {2'b0, mag_s2[l]};
			else dv = ~{2'b0, mag_s2[l]} + 36'd1;
			vw = {{4{item_s2.vel[l][31]}}, item_s2.vel[l]} + dv;
			if (vw[35:31] == 5'b00000 || vw[35:31] == 5'b11111) nv_c[l] = vw[31:0];
			else nv_c[l] = vw[35] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
	end

	always_comb begin
		logic [31:0] a;
		for (int l = 0; l < 3; l++) begin
			a = nv_s3[l][31] ? (~nv_s3[l] + 32'd1) : nv_s3[l];
			pd_c[l] = 64'(a) * 64'(dt);
		end
	end

	always_comb begin
		logic [51:0] dm;
		logic [64:0] d;
		for (int l = 0; l < 3; l++) begin
			dm = 52'((pd_s4[l] + 64'd2048) >> 12);
			d  = nv_s4[l][31] ? (~{13'd0, dm} + 65'd1) : {13'd0, dm};
			np_c[l] = sat64({item_s4.pos[l][63], item_s4.pos[l]} + d);
		end
	end

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			res_c.new_pos[l] = np_s5[l];
			res_c.new_vel[l] = nv_s5[l];
			res_c.view[l]    = sat64({np_s5[l][63], np_s5[l]} - {cam[l][63], cam[l]});
		end
		res_c.new_life = item_s5.life - dt;
		res_c.tag      = item_s5.tag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= in_item;
			for (int l = 0; l < 3; l++) begin
				plo_s1[l] <= 63'(kc[31:0] * {1'b0, in_item.u[l]});
				phi_s1[l] <= 63'(kc[63:32] * {1'b0, in_item.u[l]});
			end
			item_s2 <= item_s1;
			mag_s2  <= mag_c;
			item_s3 <= item_s2;
			nv_s3   <= nv_c;
			item_s4 <= item_s3;
			nv_s4   <= nv_s3;
			pd_s4   <= pd_c;
			item_s5 <= item_s4;
			nv_s5   <= nv_s4;
			np_s5   <= np_c;
			res_s6  <= res_c;
		end
	end

	assign out_vld = vld_s6;
	assign out_res = res_s6;

endmodule

/* src/particle_central_gravity_step_unit.sv */
// Top level: one semi-implicit Euler step of a particle under central gravity.
//
// channel  dir  handshake                  payload
// cfg      in   psel/penable/pwrite/pready paddr[4:3] = register, pwdata/prdata 64 bit
// s_*      in   s_tvalid/s_tready          s_tdata: particle word
// m_*      out  m_tvalid/m_tready          m_tdata: updated particle word
//
// One word per cycle sustained while m_tready is high; 183 register stages in all:
// 4 front stages, 32 square-root stages, 31 unit-vector divide stages,
// 110 stages of the gravity-factor long divider (a scaling stage, then one
// quotient bit each), 6 back stages.
// Expired particles are accepted and dropped in the first stage.
// Reset clears all valid bits and loads the register reset values.
// The whole pipeline holds while the output word waits and m_tready is low.
module particle_central_gravity_step_unit (
	input  logic         clk,
	input  logic         arst_n,
	// configuration port
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready,
	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	// pos_x, pos_y, pos_z (64 each), vel_x, vel_y, vel_z (32 each), life_left (32),
	// source_tag (16)
	input  logic [335:0] s_tdata,
	// output stream
	output logic         m_tvalid,
	input  logic         m_tready,
	// new_pos_x, new_pos_y, new_pos_z (64 each), new_vel_x, new_vel_y, new_vel_z (32 each),
	// new_life (32), view_x, view_y, view_z (64 each), tag_out (16)
	output logic [527:0] m_tdata
);

	logic [31:0]       step_q;
	logic [2:0][63:0]  cam_q;
	logic [63:0]       mu_lo_q;
	logic [48:0]       mu_hi_q;
	logic [pcg_pkg::MUDT_W-1:0] mudt_q;
	logic              wr;
	logic              adv;

	pcg_pkg::pcg_item_t   in_item, fr_item, sq_item, ud_item, kd_item;
	logic                 fr_vld, sq_vld, ud_vld, kd_vld;
	pcg_pkg::pcg_result_t res;

	// config registers; the user must write them only while the pipeline is empty, the block does not enforce it
	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 32'd1092;
			cam_q  <= '0;
		end else if (wr) begin
			case (pcg_pkg::reg_idx_t'(paddr[4:3]))
				pcg_pkg::REG_STEP:  step_q   <= pwdata[31:0];
				pcg_pkg::REG_CAM_X: cam_q[0] <= pwdata;
				pcg_pkg::REG_CAM_Y: cam_q[1] <= pwdata;
				pcg_pkg::REG_CAM_Z: cam_q[2] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (pcg_pkg::reg_idx_t'(paddr[4:3]))
			pcg_pkg::REG_STEP:  prdata = {32'd0, step_q};
			pcg_pkg::REG_CAM_X: prdata = cam_q[0];
			pcg_pkg::REG_CAM_Y: prdata = cam_q[1];
			pcg_pkg::REG_CAM_Z: prdata = cam_q[2];
			default:            prdata = '0;
		endcase
	end

	// MU*dt follows step_q through the mu_lo_q/mu_hi_q and mudt_q registers; an item passes
	// the front, square-root and unit-vector stages before the divider, so it always sees the settled product.
	always_ff @(posedge clk) begin
		mu_lo_q <= 64'(pcg_pkg::GRAV_MU[31:0]) * 64'(step_q);
		mu_hi_q <= 49'(pcg_pkg::GRAV_MU[48:32]) * 49'(step_q);
		mudt_q  <= {mu_hi_q, 32'd0} + pcg_pkg::MUDT_W'(mu_lo_q);
	end

	// global pipeline advance
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	always_comb begin
		in_item        = '0;
		in_item.pos[0] = s_tdata[63:0];
		in_item.pos[1] = s_tdata[127:64];
		in_item.pos[2] = s_tdata[191:128];
		in_item.vel[0] = s_tdata[223:192];
		in_item.vel[1] = s_tdata[255:224];
		in_item.vel[2] = s_tdata[287:256];
		in_item.life   = s_tdata[319:288];
		in_item.tag    = s_tdata[335:320];
	end

	pcg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (s_tvalid),
		.in_item  (in_item),
		.dt       (step_q),
		.out_vld  (fr_vld),
		.out_item (fr_item)
	);

	pcg_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (fr_vld),
		.in_item  (fr_item),
		.out_vld  (sq_vld),
		.out_item (sq_item)
	);

	pcg_udiv u_udiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (sq_vld),
		.in_item  (sq_item),
		.out_vld  (ud_vld),
		.out_item (ud_item)
	);

	pcg_kdiv u_kdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (ud_vld),
		.in_item  (ud_item),
		.mudt     (mudt_q),
		.out_vld  (kd_vld),
		.out_item (kd_item)
	);

	pcg_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (kd_vld),
		.in_item  (kd_item),
		.dt       (step_q),
		.cam      (cam_q),
		.out_vld  (m_tvalid),
		.out_res  (res)
	);

	assign m_tdata = {res.tag, res.view[2], res.view[1], res.view[0], res.new_life,
		res.new_vel[2], res.new_vel[1], res.new_vel[0],
		res.new_pos[2], res.new_pos[1], res.new_pos[0]};

	// a surviving particle always has time left
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[319:288] != 32'd0))
		else $error("output word with zero lifetime");

	// a waiting output word stalls the input side
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("input accepted while output stalled");

	// a stall freezes the valid bits inside the pipeline
	assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> ($stable(fr_vld) && $stable(sq_vld) && $stable(kd_vld)))
		else $error("pipeline moved during stall");

endmodule

/* bench/particle_central_gravity_step_checker.sv */
// Checker for the particle gravity step unit: predicts each updated particle and compares it.
`timescale 1ns / 100ps

module particle_central_gravity_step_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [63:0]  pwdata,
	input  logic         pready,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [335:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [527:0] m_tdata,
	output int           errors,
	output int           waiting,
	output int           checked,
	output int           dropped
);

	logic [31:0]          step_len;
	logic signed [63:0]   cam [3];
	pcg_pkg::pcg_result_t expected_steps [$];

	function automatic logic [63:0] isqrt(input logic [63:0] n);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n   = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic logic signed [63:0] clamp65(input logic signed [64:0] t);
		if (t > 65'sh0_7FFF_FFFF_FFFF_FFFF)
			return 64'sh7FFF_FFFF_FFFF_FFFF;
		if (t < -65'sh0_8000_0000_0000_0000)
			return 64'sh8000_0000_0000_0000;
		return t[63:0];
	endfunction

	// One semi-implicit Euler step under central gravity.
	function automatic pcg_pkg::pcg_result_t advance_particle(input logic [335:0] w);
		pcg_pkg::pcg_result_t res;
		logic signed [63:0] p [3];
		logic signed [31:0] v [3];
		logic [63:0]        mg [3], q [3];
		logic [63:0]        m, r2, r, kc, u, mag, dm, nm;
		logic [127:0]       k, prod;
		logic signed [63:0] dv, nv, d, np;
		int                 s;
		m  = 0;
		r2 = 0;
		r  = 0;
		kc = 0;
		for (int i = 0; i < 3; i++) begin
			p[i]  = w[64*i +: 64];
			v[i]  = w[192 + 32*i +: 32];
			mg[i] = p[i][63] ? 64'd0 - p[i] : p[i];
			if (mg[i] > m)
				m = mg[i];
		end
		s = 0;
		while ((m >> s) >= 64'h8000_0000)
			s++;
		for (int i = 0; i < 3; i++) begin
			q[i] = mg[i] >> s;
			r2   = r2 + q[i] * q[i];
		end
		if (r2 != 0) begin
			r = isqrt(r2);
			k = 128'(pcg_pkg::GRAV_MU) * 128'(step_len);
			if (s <= 14)
				k = (k << (28 - 2*s)) / 128'(r2);
			else
				k = (k / 128'(r2)) >> (2*s - 28);
			kc = (k[127:64] != 0) ? '1 : k[63:0];
		end
		for (int i = 0; i < 3; i++) begin
			dv = 0;
			if (r2 != 0) begin
				u    = (q[i] << 30) / r;
				prod = 128'(kc) * 128'(u) + (128'd1 << 29);
				mag  = (prod[127:94] != 0) ? 64'(pcg_pkg::DV_CAP) : prod[93:30];
				if (mag > 64'(pcg_pkg::DV_CAP))
					mag = 64'(pcg_pkg::DV_CAP);
				dv = p[i][63] ? $signed(mag) : -$signed(mag);
			end
			nv = v[i] + dv;
			if (nv > 64'sd2147483647)
				nv = 64'sd2147483647;
			if (nv < -64'sd2147483648)
				nv = -64'sd2147483648;
			nm = nv[63] ? 64'd0 - nv : nv;
			dm = (nm * 64'(step_len) + 64'd2048) >> 12;
			d  = nv[63] ? -$signed(dm) : $signed(dm);
			np = clamp65({p[i][63], p[i]} + {d[63], d});
			res.new_pos[i] = np;
			res.new_vel[i] = nv[31:0];
			res.view[i]    = clamp65({np[63], np} - {cam[i][63], cam[i]});
		end
		res.new_life = w[319:288] - step_len;
		res.tag      = w[335:320];
		return res;
	endfunction

	task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
		$display("%0t mismatch %s: expected %h got %h", $realtime, what, want, got);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		pcg_pkg::pcg_result_t want;
		if (!arst_n) begin
			step_len = 32'd1092;
			cam[0]   = 0;
			cam[1]   = 0;
			cam[2]   = 0;
			errors   = 0;
			checked  = 0;
			dropped  = 0;
			expected_steps.delete();
			waiting  = 0;
		end else begin
			// output side first: a word accepted now entered the pipe earlier, so its prediction is already queued
			if (m_tvalid && m_tready) begin
				if (expected_steps.size() == 0) begin
					report("unexpected word", 0, m_tdata[63:0]);
				end else begin
					want = expected_steps.pop_front();
					checked++;
					for (int i = 0; i < 3; i++) begin
						if (m_tdata[64*i +: 64] !== want.new_pos[i])
							report($sformatf("new_pos[%0d]", i), want.new_pos[i],
								m_tdata[64*i +: 64]);
						if (m_tdata[192 + 32*i +: 32] !== want.new_vel[i])
							report($sformatf("new_vel[%0d]", i), want.new_vel[i],
								m_tdata[192 + 32*i +: 32]);
						if (m_tdata[320 + 64*i +: 64] !== want.view[i])
							report($sformatf("view[%0d]", i), want.view[i],
								m_tdata[320 + 64*i +: 64]);
					end
					if (m_tdata[319:288] !== want.new_life)
						report("new_life", want.new_life, m_tdata[319:288]);
					if (m_tdata[527:512] !== want.tag)
						report("tag_out", want.tag, m_tdata[527:512]);
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tdata[319:288] > step_len)
					expected_steps.push_back(advance_particle(s_tdata));
				else
					dropped++;
			end
			if (psel && penable && pwrite && pready) begin
				case (pcg_pkg::reg_idx_t'(paddr[4:3]))
					pcg_pkg::REG_STEP:  step_len = pwdata[31:0];
					pcg_pkg::REG_CAM_X: cam[0]   = pwdata;
					pcg_pkg::REG_CAM_Y: cam[1]   = pwdata;
					pcg_pkg::REG_CAM_Z: cam[2]   = pwdata;
					default: ;
				endcase
			end
			waiting = expected_steps.size();
		end
	end

endmodule

/* bench/particle_central_gravity_step_unit_tb.sv */
// Testbench top for the particle gravity step unit: stimulus, register setup and verdict.
`timescale 1ns / 100ps

module particle_central_gravity_step_unit_tb;

	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 200;   // more than the 183 register stages of the pipeline

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0]   paddr = '0;
	logic [63:0]  pwdata = '0;
	logic [63:0]  prdata;
	logic         pready;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [335:0] s_tdata = '0;   // pos x,y,z (64), vel x,y,z (32), life (32), tag (16)
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [527:0] m_tdata;        // new pos (3x64), new vel (3x32), life, view (3x64), tag
	int           errors, waiting, checked, dropped;
	bit           calm = 1'b0;    // no idling on either side while set
	int           quiet_cycles = 0;
	logic [31:0]  step_now = 32'd1092;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	particle_central_gravity_step_unit dut (.*);

	particle_central_gravity_step_checker chk (.*);

	// receiver back-pressure
	always @(negedge clk)
		m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 22);

	// watchdog: counts cycles with work outstanding but no word moving
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (waiting == 0 && !s_tvalid))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog expired with %0d words outstanding", waiting);
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send(input logic [335:0] w);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(99) < 22) begin
				s_tvalid <= 1'b0;
			end else begin
				s_tvalid <= 1'b1;
				s_tdata  <= w;
				break;
			end
		end
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic stop_sending();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	// block idle: no word in flight, and no dropped word still inside
	task automatic drain();
		stop_sending();
		while (waiting != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input pcg_pkg::reg_idx_t idx, input logic [63:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 5'(idx) << 3;
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (idx == pcg_pkg::REG_STEP)
			step_now = val[31:0];
	endtask

	task automatic setup(input logic [31:0] dt, input logic [63:0] cx, cy, cz);
		reg_write(pcg_pkg::REG_STEP, 64'(dt));
		reg_write(pcg_pkg::REG_CAM_X, cx);
		reg_write(pcg_pkg::REG_CAM_Y, cy);
		reg_write(pcg_pkg::REG_CAM_Z, cz);
	endtask

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	// signed value spread over all magnitudes
	function automatic logic [63:0] spread64();
		logic signed [63:0] x;
		x = rnd64();
		return x >>> $urandom_range(63);
	endfunction

	function automatic logic [31:0] spread32();
		logic signed [31:0] x;
		x = $urandom;
		return x >>> $urandom_range(31);
	endfunction

	function automatic logic [335:0] pack(input logic [63:0] px, py, pz,
			input logic [31:0] vx, vy, vz, life, input logic [15:0] tag);
		return {tag, life, vz, vy, vx, pz, py, px};
	endfunction

	function automatic logic [335:0] random_particle();
		logic [31:0] life;
		case ($urandom_range(9))
			0:       life = $urandom_range(step_now);   // expired
			1:       life = $urandom;
			default: life = (step_now > 32'hFFFF_0000) ? $urandom :
				step_now + $urandom_range(32'hFFFF, 1);
		endcase
		return pack(spread64(), spread64(), spread64(), spread32(), spread32(), spread32(),
			life, 16'($urandom));
	endfunction

	task automatic random_phase(input int n);
		for (int i = 0; i < n; i++)
			send(random_particle());
	endtask

	localparam logic [63:0] P_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] P_MIN = 64'h8000_0000_0000_0000;
	localparam logic [31:0] V_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] V_MIN = 32'h8000_0000;

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed, reset register values
		send(pack(0, 0, 0, 0, 0, 0, 32'd5000, 16'h0000));               // zero radius
		send(pack(0, 0, 0, V_MAX, V_MIN, 1, 32'hFFFF_FFFF, 16'hFFFF));
		send(pack(64'd1, 0, 0, 0, 0, 0, 32'd1093, 16'h1234));            // tiny radius, capped
		send(pack(0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, 32'd2000, 16'h0001));
		send(pack(P_MAX, P_MAX, P_MAX, V_MAX, V_MAX, V_MAX, 32'd9999, 16'h00FF));
		send(pack(P_MIN, P_MIN, P_MIN, V_MIN, V_MIN, V_MIN, 32'd9999, 16'hFF00));
		send(pack(P_MAX, P_MIN, 64'd1 << 30, 0, 0, 0, 32'd3000, 16'h5555));
		send(pack(64'd1 << 31, 64'd1 << 31, 64'd1 << 31, 0, 0, 0, 32'd3000, 16'hAAAA));
		send(pack(64'h7FFF_FFFF, 0, 0, 0, 0, 0, 32'd1092, 16'h7777));   // life equals step
		send(pack(64'd1 << 40, 0, 0, 0, 0, 0, 32'd1093, 16'h8888));     // just survives
		send(pack(64'd12345, 64'd1, 64'd1, V_MAX, V_MIN, 0, 32'd0, 16'h9999));   // dead
		drain();

		// long step, cameras at the extremes: position and view saturate
		setup(32'hFFFF_FFFE, P_MAX, P_MIN, 0);
		send(pack(P_MAX - 64'd5, P_MIN + 64'd5, 0, V_MAX, V_MIN, V_MAX,
			32'hFFFF_FFFF, 16'h0F0F));
		send(pack(P_MIN, P_MAX, P_MAX, V_MIN, V_MAX, 0, 32'hFFFF_FFFF, 16'hF0F0));
		send(pack(64'd100, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 16'h0102));
		send(pack(64'd100, 0, 0, 0, 0, 0, 32'hFFFF_FFFE, 16'h0304));    // expired
		drain();

		// zero step: nothing moves except by zero, only life 0 is dropped
		setup(32'd0, P_MIN, P_MAX, P_MIN);
		send(pack(P_MIN, 0, 0, 0, 0, 0, 32'd1, 16'h0506));
		send(pack(64'd7, 64'd7, 64'd7, V_MAX, 0, 0, 32'd0, 16'h0708));
		random_phase(40);
		drain();

		// largest step: every particle is dropped
		setup(32'hFFFF_FFFF, rnd64(), rnd64(), rnd64());
		random_phase(20);
		drain();

		// random settings, with a stretch of no idling in one of them
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: setup(32'd1092, 0, 0, 0);
				1: setup($urandom_range(32'h0010_0000), spread64(), spread64(), spread64());
				2: setup($urandom, rnd64(), rnd64(), rnd64());
				default: setup($urandom_range(16), spread64(), spread64(), spread64());
			endcase
			calm = (ph == 4);
			random_phase(155);
			calm = 1'b0;
			drain();   // sender holds off until every word has come back
		end

		$display("%0d particles updated and checked, %0d expired particles dropped,",
			checked, dropped);
		$display("over reset, zero, largest and random step and camera settings");
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
